/* rtl/core/q8dot_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q8dot_pkg
// Shared constants and types of the block-quantised int8 dot product.
// ----------------------------------------------------------------------------
package q8dot_pkg;

    localparam int LANES      = 8;
    localparam int W_WIDTH    = 8;
    localparam int ACT_WIDTH  = 16;
    localparam int SCALE_W    = 16;
    localparam int BSIZE_W    = 8;
    localparam int RESULT_W   = 64;
    localparam int PROD_W     = W_WIDTH + ACT_WIDTH;
    localparam int SUM_W      = PROD_W + $clog2(LANES);
    localparam int TERM_W     = SUM_W + SCALE_W;
    localparam int WPACK_W    = W_WIDTH * LANES;

    localparam logic [BSIZE_W-1:0] BLK_LEN_OK = BSIZE_W'(32);

    typedef logic signed [PROD_W-1:0] q8dot_prod_t;

    // travels with each word down the pipeline
    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic signed [SCALE_W-1:0]  scale;
    } q8dot_ctl_t;

endpackage : q8dot_pkg
`default_nettype wire

/* rtl/core/q8dot_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q8dot_if
// Valid/ready channels of the dot product: group input and row result.
// ----------------------------------------------------------------------------
interface q8dot_in_if;
    logic                valid;
    logic                ready;
    logic [63:0]         weights_packed;
    logic signed [15:0]  act_0;
    logic signed [15:0]  act_1;
    logic signed [15:0]  act_2;
    logic signed [15:0]  act_3;
    logic signed [15:0]  act_4;
    logic signed [15:0]  act_5;
    logic signed [15:0]  act_6;
    logic signed [15:0]  act_7;
    logic signed [15:0]  block_scale;
    logic                last_group;

    modport source (
        output valid, weights_packed, act_0, act_1, act_2, act_3,
               act_4, act_5, act_6, act_7, block_scale, last_group,
        input  ready
    );
    modport sink (
        input  valid, weights_packed, act_0, act_1, act_2, act_3,
               act_4, act_5, act_6, act_7, block_scale, last_group,
        output ready
    );
endinterface : q8dot_in_if

interface q8dot_out_if;
    logic                valid;
    logic                ready;
    logic signed [63:0]  dot_result;

    modport source (output valid, dot_result, input ready);
    modport sink   (input valid, dot_result, output ready);
endinterface : q8dot_out_if
`default_nettype wire

/* rtl/core/q8dot_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q8dot_lane
// One multiply lane: signed weight times signed activation, registered.
// ----------------------------------------------------------------------------
module q8dot_lane (
    input  wire logic                                  clk,
    input  wire logic                                  advance,
    input  wire logic signed [q8dot_pkg::W_WIDTH-1:0]  weight,
    input  wire logic signed [q8dot_pkg::ACT_WIDTH-1:0] act,
    output q8dot_pkg::q8dot_prod_t                     product
);
    import q8dot_pkg::*;

    q8dot_prod_t product_reg;
    q8dot_prod_t product_next;

    always_comb
    begin
        product_next = PROD_W'(weight) * PROD_W'(act);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule : q8dot_lane
`default_nettype wire

/* rtl/core/q8dot_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q8dot_merge
// Adds the lane products and scales the group sum, two register stages.
// ----------------------------------------------------------------------------
module q8dot_merge (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  q8dot_pkg::q8dot_ctl_t                  ctl_in,
    input  q8dot_pkg::q8dot_prod_t                 products [q8dot_pkg::LANES],
    output q8dot_pkg::q8dot_ctl_t                  ctl_out,
    output logic signed [q8dot_pkg::TERM_W-1:0]    term
);
    import q8dot_pkg::*;

    q8dot_ctl_t               s2_ctl_reg;
    q8dot_ctl_t               s3_ctl_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [TERM_W-1:0] term_next;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_next = sum_next + SUM_W'(products[i]);
        end
    end

    always_comb
    begin
        term_next = TERM_W'(sum_reg) * TERM_W'(s2_ctl_reg.scale);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else if (advance)
        begin
            s2_ctl_reg <= ctl_in;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg  <= sum_next;
            term_reg <= term_next;
        end
    end

    assign ctl_out = s3_ctl_reg;
    assign term    = term_reg;

endmodule : q8dot_merge
`default_nettype wire

/* rtl/core/q8dot_accum.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q8dot_accum
// Saturating row accumulator and the result output register.
// ----------------------------------------------------------------------------
module q8dot_accum (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic [q8dot_pkg::BSIZE_W-1:0]     blk_len,
    input  q8dot_pkg::q8dot_ctl_t                  ctl,
    input  wire logic signed [q8dot_pkg::TERM_W-1:0] term,
    output logic                                   stall,
    q8dot_out_if.source                            out_chan
);
    import q8dot_pkg::*;

    logic signed [RESULT_W-1:0] acc_reg;
    logic signed [RESULT_W-1:0] acc_next;
    logic signed [RESULT_W-1:0] result_reg;
    logic signed [RESULT_W-1:0] result_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [RESULT_W:0]   wide_sum;
    logic signed [RESULT_W-1:0] sat_sum;
    logic                       fire;

    // a row result may not land while the previous one is still held
    assign stall = ctl.valid && ctl.last && out_valid_reg && !out_chan.ready;
    assign fire  = ctl.valid && advance;

    always_comb
    begin
        wide_sum = (RESULT_W + 1)'(acc_reg) + (RESULT_W + 1)'(term);
        priority if (wide_sum[RESULT_W] != wide_sum[RESULT_W-1])
        begin
            sat_sum = wide_sum[RESULT_W] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                         : {1'b0, {(RESULT_W-1){1'b1}}};
        end
        else
        begin
            sat_sum = wide_sum[RESULT_W-1:0];
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_chan.ready;
        if (fire)
        begin
            acc_next = sat_sum;
            if (ctl.last)
            begin
                acc_next       = '0;
                result_next    = (blk_len == BLK_LEN_OK) ? sat_sum : '0;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.dot_result = result_reg;

endmodule : q8dot_accum
`default_nettype wire

/* rtl/core/block_quantized_int8_dot_product.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// block_quantized_int8_dot_product
// Q8_0 block-quantised row dot product with eight multiply lanes.
// ----------------------------------------------------------------------------
// One input word (eight weights, eight activations, block scale) is taken per
// cycle. A word passes four register stages: lane multiply, group adder tree,
// scale multiply, and the saturating accumulator; a row result is shown from
// the result register after its last word has passed all four. The accumulate
// loop sets the rate of one word per cycle; input is held back only while a
// finished row result waits at the output and the next row result has reached
// the accumulator. The result carries 27 fraction bits and is zero whenever
// the configured block length is not 32. No reset sweep is needed.
// ----------------------------------------------------------------------------
module block_quantized_int8_dot_product (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [q8dot_pkg::BSIZE_W-1:0]     cfg_wdata,
    q8dot_in_if.sink                               in_chan,
    q8dot_out_if.source                            out_chan
);
    import q8dot_pkg::*;

    logic [BSIZE_W-1:0]       blk_len_reg;
    q8dot_ctl_t               s1_ctl_reg;
    q8dot_ctl_t               s1_ctl_next;
    q8dot_ctl_t               s3_ctl;
    q8dot_prod_t              products [LANES];
    logic signed [ACT_WIDTH-1:0] act_lane [LANES];
    logic signed [TERM_W-1:0] term;
    logic                     stall;
    logic                     advance;

    assign advance       = !stall;
    assign in_chan.ready = advance;

    assign act_lane[0] = in_chan.act_0;
    assign act_lane[1] = in_chan.act_1;
    assign act_lane[2] = in_chan.act_2;
    assign act_lane[3] = in_chan.act_3;
    assign act_lane[4] = in_chan.act_4;
    assign act_lane[5] = in_chan.act_5;
    assign act_lane[6] = in_chan.act_6;
    assign act_lane[7] = in_chan.act_7;

    always_comb
    begin
        s1_ctl_next.valid = in_chan.valid;
        s1_ctl_next.last  = in_chan.last_group;
        s1_ctl_next.scale = in_chan.block_scale;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_len_reg <= BLK_LEN_OK;
            s1_ctl_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                blk_len_reg <= cfg_wdata;
            end
            if (advance)
            begin
                s1_ctl_reg <= s1_ctl_next;
            end
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        q8dot_lane u_lane (
            .clk     (clk),
            .advance (advance),
            .weight  ($signed(in_chan.weights_packed[W_WIDTH*i +: W_WIDTH])),
            .act     (act_lane[i]),
            .product (products[i])
        );
    end

    q8dot_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .ctl_in   (s1_ctl_reg),
        .products (products),
        .ctl_out  (s3_ctl),
        .term     (term)
    );

    q8dot_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .blk_len    (blk_len_reg),
        .ctl        (s3_ctl),
        .term       (term),
        .stall      (stall),
        .out_chan   (out_chan)
    );

endmodule : block_quantized_int8_dot_product
`default_nettype wire

/* rtl/core/q8dot_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q8dot_checker
// Port-level checks of the dot product, bound to the top level.
// ----------------------------------------------------------------------------
module q8dot_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         cfg_we,
    input wire logic [7:0]   cfg_wdata,
    input wire logic         in_valid,
    input wire logic         in_ready,
    input wire logic         in_last,
    input wire logic         out_valid,
    input wire logic         out_ready,
    input wire logic [63:0]  dot_result
);
    logic [7:0] bsize_reg;
    logic [3:0] pending_reg;
    logic [3:0] pending_next;

    // rows whose last word went in but whose result has not gone out
    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready && in_last)
        begin
            pending_next = pending_next + 4'd1;
        end
        if (out_valid && out_ready)
        begin
            pending_next = pending_next - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg   <= 8'd32;
            pending_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bsize_reg <= cfg_wdata;
            end
            pending_reg <= pending_next;
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result word shown during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dot_result))
        else $error("stalled result word dropped or changed");

    a_bad_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bsize_reg != 8'd32 |-> dot_result == 64'd0)
        else $error("non-zero result with wrong block size");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result word without a last input word");

endmodule : q8dot_checker

bind block_quantized_int8_dot_product q8dot_checker u_q8dot_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_last    (in_chan.last_group),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .dot_result (out_chan.dot_result)
);
`default_nettype wire
